// ===== design/bvs_pkg.sv =====
// Package for the bounded vector store: command and status codes, the
// request and response word types, and the decode result type.
// No dependencies.
package bvs_pkg;

   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 8;
   localparam int CNT_W    = 9;
   localparam int CAPACITY = 256;

   typedef enum logic [2:0] {
      CMD_PUSH    = 3'd0,
      CMD_POP     = 3'd1,
      CMD_SET     = 3'd2,
      CMD_INSERT  = 3'd3,
      CMD_READ    = 3'd4,
      CMD_REVERSE = 3'd5,
      CMD_CLEAR   = 3'd6,
      CMD_NOP     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [DATA_W-1:0]   value;
      logic        [ADDR_W-1:0]   index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   read_data;
      logic        [CNT_W-1:0]    element_count;
      logic                       is_empty;
      status_type                 status;
   } rsp_type;

   // Decode of one command against the current element count
   typedef struct packed {
      status_type status;
      logic       do_op;        // command changes state (or reads) as asked
      logic       rd_in_range;  // read index below the count
   } check_type;

endpackage

// ===== design/bvs_check.sv =====
// Command check for the bounded vector store: bounds and capacity tests
// that set the status and whether the command takes effect.
// Depends on bvs_pkg.
module bvs_check (
   input  bvs_pkg::cmd_type                 cmd,
   input  logic [bvs_pkg::ADDR_W-1:0]       index,
   input  logic [bvs_pkg::CNT_W-1:0]        count,
   output bvs_pkg::check_type               chk
);

   logic idx_ok;
   logic full;
   logic empty;

   assign idx_ok = ({1'b0, index} < count);
   assign full   = (count >= bvs_pkg::CNT_W'(bvs_pkg::CAPACITY));
   assign empty  = (count == '0);

   // Decode status per command
   always_comb begin
      chk.status      = bvs_pkg::ST_OK;
      chk.do_op       = 1'b1;
      chk.rd_in_range = idx_ok;
      unique case (cmd)
         bvs_pkg::CMD_PUSH: begin
            if (full) begin
               chk.status = bvs_pkg::ST_FULL;
               chk.do_op  = 1'b0;
            end
         end
         bvs_pkg::CMD_POP: begin
            if (empty) begin
               chk.status = bvs_pkg::ST_EMPTY;
               chk.do_op  = 1'b0;
            end
         end
         bvs_pkg::CMD_SET: begin
            if (!idx_ok) begin
               chk.status = bvs_pkg::ST_RANGE;
               chk.do_op  = 1'b0;
            end
         end
         bvs_pkg::CMD_INSERT: begin
            if (!idx_ok) begin
               chk.status = bvs_pkg::ST_RANGE;
               chk.do_op  = 1'b0;
            end else if (full) begin
               chk.status = bvs_pkg::ST_FULL;
               chk.do_op  = 1'b0;
            end
         end
         bvs_pkg::CMD_READ: begin
            if (!idx_ok) begin
               chk.status = bvs_pkg::ST_RANGE;
            end
         end
         bvs_pkg::CMD_REVERSE: begin
            chk.do_op = (count > bvs_pkg::CNT_W'(1));
         end
         bvs_pkg::CMD_CLEAR: begin
            chk.do_op = 1'b1;
         end
         bvs_pkg::CMD_NOP: begin
            chk.do_op = 1'b0;
         end
         default: begin
            chk.do_op = 1'b0;
         end
      endcase
   end

endmodule

// ===== design/bounded_vector_store.sv =====
// Bounded vector store top level: command sequencer around a 256 x 32
// element memory with two registered read ports and one write port.
// Depends on bvs_pkg and bvs_check.
//
//   channel   ports                          word
//   request   req_valid req_stall req_data   bvs_pkg::req_type
//   response  rsp_valid rsp_stall rsp_data   bvs_pkg::rsp_type
//
// One command at a time: push, pop, set, read, clear, no-op and refused commands
// reach the response register via S_EXEC (reads also via S_READ); insert shifts
// (count - index) words up and reverse of two or more words swaps floor(count / 2)
// pairs, through the single write port (one shifted or swapped word per write).
// Reset clears the count, the sequencer and the response valid flag, not the memory.
// A stalled response only holds delivery; requests stall while a command is in progress.
module bounded_vector_store (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  bvs_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bvs_pkg::rsp_type   rsp_data
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_EXEC      = 9'b000000010,
      S_READ      = 9'b000000100,
      S_INS       = 9'b000001000,
      S_INS_DRAIN = 9'b000010000,
      S_INS_LAST  = 9'b000100000,
      S_REV_RD    = 9'b001000000,
      S_REV_WLO   = 9'b010000000,
      S_REV_WHI   = 9'b100000000
   } state_type;

   // S_DONE is folded into S_IDLE-bound completion below; see done_ff
   state_type                          state_ff, state_in;
   logic                               done_ff, done_in;
   bvs_pkg::req_type                   cmd_ff, cmd_in;
   logic [bvs_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [bvs_pkg::ADDR_W-1:0]         ptr_ff, ptr_in;
   logic [bvs_pkg::ADDR_W-1:0]         hi_ff, hi_in;
   logic                               wr_pend_ff, wr_pend_in;
   logic [bvs_pkg::ADDR_W-1:0]         wr_addr_ff, wr_addr_in;
   bvs_pkg::status_type                st_ff, st_in;
   bvs_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // Element memory
   logic signed [bvs_pkg::DATA_W-1:0]  mem [bvs_pkg::CAPACITY];
   logic                               rd_a_en, rd_b_en, wr_en;
   logic [bvs_pkg::ADDR_W-1:0]         rd_a_addr, rd_b_addr, wr_addr;
   logic signed [bvs_pkg::DATA_W-1:0]  wr_data;
   logic signed [bvs_pkg::DATA_W-1:0]  rd_a_data_ff, rd_b_data_ff;

   bvs_pkg::check_type                 chk;
   logic                               rsp_free;

   bvs_check u_check (
      .cmd   (cmd_ff.cmd),
      .index (cmd_ff.index),
      .count (count_ff),
      .chk   (chk)
   );

   function automatic bvs_pkg::rsp_type make_rsp(
      input logic signed [bvs_pkg::DATA_W-1:0] rd,
      input logic [bvs_pkg::CNT_W-1:0]         cnt,
      input bvs_pkg::status_type               st
   );
      bvs_pkg::rsp_type r;
      r.read_data     = rd;
      r.element_count = cnt;
      r.is_empty      = (cnt == '0);
      r.status        = st;
      return r;
   endfunction

   assign req_stall = (state_ff != S_IDLE) || done_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      done_in      = done_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      hi_in        = hi_ff;
      wr_pend_in   = wr_pend_ff;
      wr_addr_in   = wr_addr_ff;
      st_in        = st_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_a_en      = 1'b0;
      rd_b_en      = 1'b0;
      rd_a_addr    = '0;
      rd_b_addr    = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      unique case (state_ff)
         S_IDLE: begin
            // Deliver a finished non-read command, else take a new word
            if (done_ff) begin
               if (rsp_free) begin
                  rsp_in       = make_rsp('0, count_ff, st_ff);
                  rsp_valid_in = 1'b1;
                  done_in      = 1'b0;
               end
            end else if (req_valid) begin
               cmd_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            st_in    = chk.status;
            done_in  = 1'b1;
            state_in = S_IDLE;
            case (cmd_ff.cmd)
               bvs_pkg::CMD_PUSH: begin
                  if (chk.do_op) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[bvs_pkg::ADDR_W-1:0];
                     wr_data  = cmd_ff.value;
                     count_in = count_ff + bvs_pkg::CNT_W'(1);
                  end
               end
               bvs_pkg::CMD_POP: begin
                  if (chk.do_op) begin
                     count_in = count_ff - bvs_pkg::CNT_W'(1);
                  end
               end
               bvs_pkg::CMD_SET: begin
                  if (chk.do_op) begin
                     wr_en   = 1'b1;
                     wr_addr = cmd_ff.index;
                     wr_data = cmd_ff.value;
                  end
               end
               bvs_pkg::CMD_CLEAR: begin
                  count_in = '0;
               end
               bvs_pkg::CMD_READ: begin
                  rd_a_en   = 1'b1;
                  rd_a_addr = chk.rd_in_range ? cmd_ff.index : '0;
                  done_in   = 1'b0;
                  state_in  = S_READ;
               end
               bvs_pkg::CMD_INSERT: begin
                  if (chk.do_op) begin
                     ptr_in     = count_ff[bvs_pkg::ADDR_W-1:0] - bvs_pkg::ADDR_W'(1);
                     wr_pend_in = 1'b0;
                     done_in    = 1'b0;
                     state_in   = S_INS;
                  end
               end
               bvs_pkg::CMD_REVERSE: begin
                  if (chk.do_op) begin
                     ptr_in   = '0;
                     hi_in    = bvs_pkg::ADDR_W'(count_ff - bvs_pkg::CNT_W'(1));
                     done_in  = 1'b0;
                     state_in = S_REV_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            // Empty store answers zero on an out-of-range read
            if (rsp_free) begin
               rsp_in = make_rsp((count_ff == '0) ? '0 : rd_a_data_ff, count_ff, st_ff);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_INS: begin
            // Shift up: read one below, write it one slot higher next cycle
            if (wr_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wr_addr_ff;
               wr_data = rd_a_data_ff;
            end
            rd_a_en    = 1'b1;
            rd_a_addr  = ptr_ff;
            wr_pend_in = 1'b1;
            wr_addr_in = ptr_ff + bvs_pkg::ADDR_W'(1);
            ptr_in     = ptr_ff - bvs_pkg::ADDR_W'(1);
            if (ptr_ff == cmd_ff.index) begin
               state_in = S_INS_DRAIN;
            end
         end
         S_INS_DRAIN: begin
            wr_en      = 1'b1;
            wr_addr    = wr_addr_ff;
            wr_data    = rd_a_data_ff;
            wr_pend_in = 1'b0;
            state_in   = S_INS_LAST;
         end
         S_INS_LAST: begin
            wr_en    = 1'b1;
            wr_addr  = cmd_ff.index;
            wr_data  = cmd_ff.value;
            count_in = count_ff + bvs_pkg::CNT_W'(1);
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         S_REV_RD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = ptr_ff;
            rd_b_en   = 1'b1;
            rd_b_addr = hi_ff;
            state_in  = S_REV_WLO;
         end
         S_REV_WLO: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            wr_data  = rd_b_data_ff;
            state_in = S_REV_WHI;
         end
         S_REV_WHI: begin
            // Finish the swap and fetch the next pair alongside
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = rd_a_data_ff;
            ptr_in  = ptr_ff + bvs_pkg::ADDR_W'(1);
            hi_in   = hi_ff - bvs_pkg::ADDR_W'(1);
            if ((hi_ff - ptr_ff) > bvs_pkg::ADDR_W'(2)) begin
               rd_a_en   = 1'b1;
               rd_a_addr = ptr_ff + bvs_pkg::ADDR_W'(1);
               rd_b_en   = 1'b1;
               rd_b_addr = hi_ff - bvs_pkg::ADDR_W'(1);
               state_in  = S_REV_WLO;
            end else begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_ff      <= 1'b0;
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      ptr_ff     <= ptr_in;
      hi_ff      <= hi_in;
      wr_addr_ff <= wr_addr_in;
      st_ff      <= st_in;
      rsp_ff     <= rsp_in;
   end

   // Memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data_ff <= mem[rd_b_addr];
      end
   end

endmodule
